@@ rtl/core/amc_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, constants and types for the amicable number checker.
// No dependencies; every other file in rtl/core refers to this package.
package amc_pkg;

    // Width of the candidate value.
    localparam int VALUE_BITS = 15;
    // Width of the reported divisor sum.
    localparam int SUM_BITS   = 17;
    // Working width: wide enough for any candidate and any reported sum.
    localparam int X_BITS     = (VALUE_BITS > SUM_BITS) ? VALUE_BITS : SUM_BITS;
    // Counter width for the remainder steps (holds X_BITS itself).
    localparam int CNT_BITS   = $clog2(X_BITS + 1);

    localparam logic [SUM_BITS-1:0] SUM_MAX   = {SUM_BITS{1'b1}};
    localparam logic [X_BITS-1:0]   SUM_MAX_X = X_BITS'(SUM_MAX);

    // Request into the shared remainder unit.
    typedef struct packed {
        logic              start;
        logic [X_BITS-1:0] dividend;
        logic [X_BITS-1:0] divisor;
    } t_rem_req;

    // Response from the shared remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT,
        ST_PASS_END,
        ST_DELIVER
    } t_state;

endpackage

@@ rtl/core/amc_rem_unit.sv @@
`timescale 1ns / 1ps
// Restoring remainder unit: one quotient bit per cycle.
// Depends on amc_pkg for widths and the request/response structs.
module amc_rem_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  amc_pkg::t_rem_req i_req,
    output amc_pkg::t_rem_rsp o_rsp
);

    logic                         r_busy;
    logic                         r_done;
    logic [amc_pkg::CNT_BITS-1:0] r_cnt;
    logic [amc_pkg::X_BITS-1:0]   r_shift;
    logic [amc_pkg::X_BITS-1:0]   r_rem;
    logic [amc_pkg::X_BITS-1:0]   r_div;

    logic [amc_pkg::X_BITS:0]     trial;
    logic [amc_pkg::X_BITS:0]     diff;
    logic [amc_pkg::X_BITS-1:0]   n_rem;

    // Shift in the next dividend bit; subtract when it fits.
    always_comb begin
        trial = {r_rem, r_shift[amc_pkg::X_BITS-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[amc_pkg::X_BITS-1:0];
        end else begin
            n_rem = trial[amc_pkg::X_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= amc_pkg::CNT_BITS'(amc_pkg::X_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == amc_pkg::CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_shift <= i_req.dividend;
            r_rem   <= '0;
            r_div   <= i_req.divisor;
        end else if (r_busy) begin
            r_shift <= {r_shift[amc_pkg::X_BITS-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.zero = (r_rem == '0);

endmodule

@@ rtl/core/amc_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: walks the trial divisors of both passes, accumulates divisor sums
// and holds the result beat. Depends on amc_pkg; drives amc_rem_unit.
module amc_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [amc_pkg::VALUE_BITS-1:0] i_candidate,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [amc_pkg::SUM_BITS-1:0]   o_divisor_sum,
    output logic                           o_is_amicable,
    output amc_pkg::t_rem_req              o_req,
    input  amc_pkg::t_rem_rsp              i_rsp
);

    amc_pkg::t_state r_state, n_state;

    logic                           r_pass, n_pass;
    logic [amc_pkg::VALUE_BITS-1:0] r_a, n_a;
    logic [amc_pkg::X_BITS-1:0]     r_x, n_x;
    logic [amc_pkg::X_BITS-1:0]     r_i, n_i;
    logic [amc_pkg::X_BITS-1:0]     r_acc, n_acc;
    logic                           r_ovf, n_ovf;
    logic [amc_pkg::SUM_BITS-1:0]   r_b, n_b;
    logic                           r_sat, n_sat;
    logic                           r_out_valid, n_out_valid;
    logic [amc_pkg::SUM_BITS-1:0]   r_out_sum, n_out_sum;
    logic                           r_out_amic, n_out_amic;

    logic                           in_beat;
    logic                           out_free;
    logic                           trials_done;
    logic [amc_pkg::X_BITS:0]       acc_sum;
    logic                           pass1_sat;
    logic [amc_pkg::X_BITS-1:0]     a_ext;
    logic                           amic;

    assign in_beat     = i_valid && (r_state == amc_pkg::ST_IDLE);
    assign out_free    = !r_out_valid || i_ready;
    assign trials_done = (r_i > (r_x >> 1));
    assign acc_sum     = {1'b0, r_acc} + {1'b0, r_i};
    assign pass1_sat   = r_ovf || (r_acc > amc_pkg::SUM_MAX_X);
    assign a_ext       = amc_pkg::X_BITS'(r_a);
    assign amic        = !r_sat && !r_ovf && (r_acc == a_ext)
                         && (a_ext != amc_pkg::X_BITS'(r_b));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            amc_pkg::ST_IDLE: begin
                if (i_valid) n_state = amc_pkg::ST_CHECK;
            end
            amc_pkg::ST_CHECK: begin
                n_state = trials_done ? amc_pkg::ST_PASS_END : amc_pkg::ST_WAIT;
            end
            amc_pkg::ST_WAIT: begin
                if (i_rsp.done) n_state = amc_pkg::ST_CHECK;
            end
            amc_pkg::ST_PASS_END: begin
                n_state = r_pass ? amc_pkg::ST_DELIVER : amc_pkg::ST_CHECK;
            end
            amc_pkg::ST_DELIVER: begin
                if (out_free) n_state = amc_pkg::ST_IDLE;
            end
            default: n_state = amc_pkg::ST_IDLE;
        endcase
    end

    // Outputs toward the input channel and the remainder unit
    always_comb begin
        o_ready        = (r_state == amc_pkg::ST_IDLE);
        o_req.start    = (r_state == amc_pkg::ST_CHECK) && !trials_done;
        o_req.dividend = r_x;
        o_req.divisor  = r_i;
    end

    // Datapath next values
    always_comb begin
        n_pass      = r_pass;
        n_a         = r_a;
        n_x         = r_x;
        n_i         = r_i;
        n_acc       = r_acc;
        n_ovf       = r_ovf;
        n_b         = r_b;
        n_sat       = r_sat;
        n_out_valid = r_out_valid;
        n_out_sum   = r_out_sum;
        n_out_amic  = r_out_amic;

        // Drop the result beat once it is taken.
        if (r_out_valid && i_ready) n_out_valid = 1'b0;

        unique case (r_state)
            amc_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_pass = 1'b0;
                    n_a    = i_candidate;
                    n_x    = amc_pkg::X_BITS'(i_candidate);
                    n_i    = amc_pkg::X_BITS'(1);
                    n_acc  = '0;
                    n_ovf  = 1'b0;
                end
            end
            amc_pkg::ST_WAIT: begin
                if (i_rsp.done) begin
                    if (i_rsp.zero) begin
                        n_acc = acc_sum[amc_pkg::X_BITS-1:0];
                        if (acc_sum[amc_pkg::X_BITS]) n_ovf = 1'b1;
                    end
                    n_i = r_i + 1'b1;
                end
            end
            amc_pkg::ST_PASS_END: begin
                if (!r_pass) begin
                    // Clamp the first sum, then sum its divisors.
                    n_sat  = pass1_sat;
                    n_b    = pass1_sat ? amc_pkg::SUM_MAX : r_acc[amc_pkg::SUM_BITS-1:0];
                    n_x    = pass1_sat ? amc_pkg::SUM_MAX_X : r_acc;
                    n_pass = 1'b1;
                    n_i    = amc_pkg::X_BITS'(1);
                    n_acc  = '0;
                    n_ovf  = 1'b0;
                end
            end
            amc_pkg::ST_DELIVER: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = r_b;
                    n_out_amic  = amic;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= amc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pass     <= n_pass;
        r_a        <= n_a;
        r_x        <= n_x;
        r_i        <= n_i;
        r_acc      <= n_acc;
        r_ovf      <= n_ovf;
        r_b        <= n_b;
        r_sat      <= n_sat;
        r_out_sum  <= n_out_sum;
        r_out_amic <= n_out_amic;
    end

    assign o_valid       = r_out_valid;
    assign o_divisor_sum = r_out_sum;
    assign o_is_amicable = r_out_amic;

endmodule

@@ rtl/core/amicable_number_checker.sv @@
`timescale 1ns / 1ps
// Amicable number checker: one candidate in, its proper-divisor sum and an
// amicable flag out. Uses amc_pkg, amc_ctrl and amc_rem_unit.
//
// Each beat on the input channel carries a candidate a. The block sums the
// proper divisors of a by trial division over every i from 1 to a/2, giving
// b (saturated at the top of the 17-bit output), then sums the proper
// divisors of b the same way and flags a as amicable when that second sum
// equals a, a differs from b and b is not saturated. One item is in work at a
// time: o_ready is high only while the sequencer is idle. Every trial runs
// through a single shared restoring remainder unit that resolves one bit per
// cycle. The result sits in an output register, so a new candidate is taken
// while the previous result still waits for i_ready. No state carries over
// between items and no clearing pass follows reset.
module amicable_number_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [amc_pkg::VALUE_BITS-1:0] i_candidate,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [amc_pkg::SUM_BITS-1:0]   o_divisor_sum,
    output logic                           o_is_amicable
);

    amc_pkg::t_rem_req rem_req;
    amc_pkg::t_rem_rsp rem_rsp;

    // Sequencer: trial loop, sum accumulation, result beat.
    amc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_candidate   (i_candidate),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_divisor_sum (o_divisor_sum),
        .o_is_amicable (o_is_amicable),
        .o_req         (rem_req),
        .i_rsp         (rem_rsp)
    );

    // Shared remainder unit: answers "does i divide x" for every trial.
    amc_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

endmodule

@@ rtl/core/amc_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the amicable number checker, bound to the top.
// Depends on amc_pkg for port widths.
module amc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [amc_pkg::SUM_BITS-1:0]   o_divisor_sum,
    input logic                           o_is_amicable
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_divisor_sum)
                                   && $stable(o_is_amicable)))
        else $error("result beat changed while stalled");

    // Taking a candidate closes the input channel for the work that follows.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while previous candidate still in work");

    // An amicable partner can never be zero.
    a_amic_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_amicable) |-> (o_divisor_sum != '0))
        else $error("amicable flag with zero divisor sum");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

endmodule

bind amicable_number_checker amc_checker u_amc_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for amicable_number_checker: candidate beats in, divisor-sum and
// amicable-flag beats out, each one checked against a behavioral prediction.
// Depends on amc_pkg and the amicable_number_checker RTL; reads no files.
module testbench;

    localparam int                CLK_PERIOD_NS  = 12;
    localparam int                RESET_CYCLES   = 12;
    localparam int                RANDOM_ITEMS   = 100;
    // Receiver hold-off right after reset. It outlasts the first few quick candidates,
    // so the output register fills and the block has to drop o_ready.
    localparam int                HOLDOFF_CYCLES = 3000;
    // Any stray result beat shows up within a few trials once the last one is in.
    localparam int                DRAIN_CYCLES   = 64;
    localparam int                REPORT_LIMIT   = 10;
    // The timeout covers the slowest legal run: one full-range candidate, the all-ones
    // candidate and up to ~100 mid-range candidates, plus stalls.
    localparam longint unsigned   TIMEOUT_NS     = 64'd360_000_000;

    typedef logic [amc_pkg::VALUE_BITS-1:0] t_candidate;

    typedef struct packed {
        logic [amc_pkg::SUM_BITS-1:0] divisor_sum;
        logic                         is_amicable;
    } t_verdict;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic                         o_ready;
    t_candidate                   i_candidate = '0;
    logic                         o_valid;
    logic                         i_ready     = 1'b0;
    logic [amc_pkg::SUM_BITS-1:0] o_divisor_sum;
    logic                         o_is_amicable;

    t_candidate  pending_candidates[$];
    t_verdict    expected_verdicts[$];
    int unsigned mismatches    = 0;
    int unsigned send_gap      = 0;
    int unsigned stall_left    = 0;
    bit          receiver_calm = 1'b0;
    int unsigned holdoff_left  = HOLDOFF_CYCLES;

    amicable_number_checker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_candidate   (i_candidate),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_divisor_sum (o_divisor_sum),
        .o_is_amicable (o_is_amicable)
    );

    initial begin
        forever #(CLK_PERIOD_NS / 2) i_clk = ~i_clk;
    end

    // Sum of every i in 1..x/2 that divides x; 0 and 1 have no such i.
    function automatic longint unsigned proper_divisor_total(longint unsigned x);
        longint unsigned total;
        total = 0;
        for (longint unsigned i = 1; i <= x / 2; i++) begin
            if (x % i == 0)
                total += i;
        end
        return total;
    endfunction

    // Partner b is the divisor sum of a, clamped to the output width. The flag needs the
    // sum of b to come back to a, a different from b (rules out perfect numbers and
    // zero), and an unclamped b (a clamped partner is not the true one).
    function automatic t_verdict predict_verdict(t_candidate a);
        longint unsigned partner;
        bit              saturated;
        t_verdict        v;
        partner   = proper_divisor_total(a);
        saturated = partner > amc_pkg::SUM_MAX;
        if (saturated)
            partner = amc_pkg::SUM_MAX;
        v.divisor_sum = partner[amc_pkg::SUM_BITS-1:0];
        v.is_amicable = !saturated && proper_divisor_total(partner) == a && a != partner;
        return v;
    endfunction

    // Idle stretch between beats: mostly none or short, now and then long.
    function automatic int unsigned pick_idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    // Keep most random candidates small: an item runs a/2 + b/2 trials. Mix in some
    // mid-range values and a few notable ones.
    function automatic t_candidate pick_random_candidate();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            case ($urandom_range(0, 7))
                0: return t_candidate'(6);
                1: return t_candidate'(28);
                2: return t_candidate'(220);
                3: return t_candidate'(284);
                4: return t_candidate'(496);
                5: return t_candidate'(1184);
                6: return t_candidate'(1210);
                default: return t_candidate'(945);
            endcase
        end
        if (roll < 18)
            return t_candidate'($urandom_range(256, 1023));
        return t_candidate'($urandom_range(0, 255));
    endfunction

    // Driver: take the next candidate from the pending queue once the current beat is
    // accepted and the chosen gap has run out. Predict the result at the accepting
    // edge, so the expectation queue follows the order of acceptance.
    always @(posedge i_clk) begin : driver
        bit offering;
        offering = i_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_verdicts.push_back(predict_verdict(i_candidate));
                offering = 1'b0;
            end
            // Hold valid and payload steady while a beat is still on offer.
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_candidates.size() > 0) begin
                    i_valid     <= 1'b1;
                    i_candidate <= pending_candidates.pop_front();
                    // A calm stretch sends back to back; otherwise draw a gap.
                    send_gap    = ($urandom_range(0, 3) == 0) ? 0 : pick_idle_length();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Hold-off counter for the receiver, in a process of its own: count down from
    // reset release, and keep i_ready low until it reaches zero.
    always @(posedge i_clk) begin
        if (i_rst_n && holdoff_left > 0)
            holdoff_left <= holdoff_left - 1;
    end

    // Monitor: check each accepted result beat against the oldest prediction, then
    // choose whether to stall the next cycle.
    always @(posedge i_clk) begin : monitor
        t_verdict want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result beat: divisor_sum=%0d is_amicable=%0b",
                                 o_divisor_sum, o_is_amicable);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_divisor_sum !== want.divisor_sum
                            || o_is_amicable !== want.is_amicable) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"result mismatch: divisor_sum exp %0d got %0d, ",
                                      "is_amicable exp %0b got %0b"},
                                     want.divisor_sum, o_divisor_sum,
                                     want.is_amicable, o_is_amicable);
                    end
                end
                // Sometimes run without stalls until the next result.
                receiver_calm = ($urandom_range(0, 3) == 0);
            end
            if (holdoff_left > 0) begin
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!receiver_calm && $urandom_range(0, 2) == 0) begin
                stall_left = pick_idle_length();
                i_ready    <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : sequencer
        int unsigned k;
        int unsigned wide_slot;
        // Put the quick cases first, so they all land inside the receiver hold-off:
        // zero and one (empty trial range; zero is its own partner, so no flag), small
        // primes and even numbers, and perfect numbers (partner equals candidate).
        pending_candidates.push_back(t_candidate'(0));
        pending_candidates.push_back(t_candidate'(1));
        pending_candidates.push_back(t_candidate'(2));
        pending_candidates.push_back(t_candidate'(3));
        pending_candidates.push_back(t_candidate'(4));
        pending_candidates.push_back(t_candidate'(6));
        pending_candidates.push_back(t_candidate'(12));
        pending_candidates.push_back(t_candidate'(28));
        pending_candidates.push_back(t_candidate'(97));
        // Amicable pairs from both sides, an odd abundant number, a larger perfect one.
        pending_candidates.push_back(t_candidate'(220));
        pending_candidates.push_back(t_candidate'(284));
        pending_candidates.push_back(t_candidate'(496));
        pending_candidates.push_back(t_candidate'(945));
        pending_candidates.push_back(t_candidate'(1184));
        pending_candidates.push_back(t_candidate'(1210));
        pending_candidates.push_back(t_candidate'(2620));
        // All ones: every candidate bit high, and the slowest directed item.
        pending_candidates.push_back({amc_pkg::VALUE_BITS{1'b1}});

        // Random part: place exactly one full-range candidate, keep the rest cheap.
        wide_slot = $urandom_range(0, RANDOM_ITEMS - 1);
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == wide_slot)
                pending_candidates.push_back(
                    t_candidate'($urandom_range(0, (1 << amc_pkg::VALUE_BITS) - 1)));
            else
                pending_candidates.push_back(pick_random_candidate());
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Advance until every candidate has gone out and every result has come back.
        while (pending_candidates.size() > 0 || i_valid || expected_verdicts.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
